FILE: sv/owm_pkg.sv
// ----------------------------------------------------------------------------
// owm_pkg
// shared types, codes and register defaults of the one-wire slot engine
// ----------------------------------------------------------------------------
package owm_pkg;

  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned COUNT_W    = 10;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_RLOW  = 3'd1,
    PH_RWAIT = 3'd2,
    PH_RTAIL = 3'd3,
    PH_SLOW  = 3'd4,
    PH_SREL  = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_RESET = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_RESET_TAIL    = 3'd2,
    REG_SHORT_LOW     = 3'd3,
    REG_READ_LOW      = 3'd4,
    REG_SLOT          = 3'd5,
    REG_RECOVERY      = 3'd6
  } reg_idx_t;

  localparam logic [9:0] RESET_LOW_DEF     = 10'd480;
  localparam logic [9:0] PRESENCE_WAIT_DEF = 10'd80;
  localparam logic [9:0] RESET_TAIL_DEF    = 10'd400;
  localparam logic [3:0] SHORT_LOW_DEF     = 4'd1;
  localparam logic [3:0] READ_LOW_DEF      = 4'd2;
  localparam logic [6:0] SLOT_DEF          = 7'd60;
  localparam logic [3:0] RECOVERY_DEF      = 4'd1;

  // a zero duration counts as one tick
  function automatic logic [COUNT_W-1:0] at_least_one(input logic [COUNT_W-1:0] v);
    at_least_one = (v == '0) ? COUNT_W'(1) : v;
  endfunction

endpackage

FILE: sv/one_wire_master_slot_engine.sv
// ----------------------------------------------------------------------------
// one_wire_master_slot_engine
// one-wire bus master sequencer advanced by one tick item per bus microsecond
// ----------------------------------------------------------------------------
// Each input item is one bus tick: func selects tick only, reset, write byte
// or read byte (taken only when idle), write_byte is the byte to send and
// bus_level the sampled bus. Each item gives exactly one result item with
// drive_low, busy_res, done_res, presence and read_byte.
// Both channels use valid/stall; an item moves on an edge where valid is high
// and stall is low. The sequencer state is updated on the accepting edge and
// the result lands in an output register, so a result appears in the cycle after
// its item, and one item per cycle is taken while the output is drained.
// When out_stall holds a waiting result, in_stall is raised in the same cycle
// and the pending result stays put until it is taken.
// Timing registers are written via cfg_we/cfg_index/cfg_data; the user must
// write them only while idle (the block does not check); index 7 is ignored.
// Synchronous reset loads the default timings, returns the sequencer to idle,
// clears presence and the held read byte and empties the output register.
// ----------------------------------------------------------------------------
module one_wire_master_slot_engine (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [owm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [owm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         func,
  input  logic [7:0]                         write_byte,
  input  logic                               bus_level,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               drive_low,
  output logic                               busy_res,
  output logic                               done_res,
  output logic                               presence,
  output logic [7:0]                         read_byte
);

  localparam int unsigned CW = owm_pkg::COUNT_W;

  // timing registers
  logic [9:0] reset_low_time, presence_wait_time, reset_tail_time;
  logic [3:0] short_low_time, read_low_time, recovery_time;
  logic [6:0] slot_time;

  // sequencer state
  owm_pkg::phase_t phase, phase_next;
  logic [CW-1:0]   tick_count, tick_count_next;
  logic [2:0]      bit_index, bit_index_next;
  logic [7:0]      shift_byte, shift_byte_next;
  logic            presence_flag, presence_flag_next;
  logic            op_is_read, op_is_read_next;
  logic [7:0]      held_read, held_read_next;

  // state after a possible command start
  owm_pkg::phase_t ph0;
  logic [CW-1:0]   tc0;
  logic [2:0]      bi0;
  logic [7:0]      sb0;
  logic            opr0;

  logic            accept;
  logic            tick_busy, tick_drive, tick_done;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_time     <= owm_pkg::RESET_LOW_DEF;
      presence_wait_time <= owm_pkg::PRESENCE_WAIT_DEF;
      reset_tail_time    <= owm_pkg::RESET_TAIL_DEF;
      short_low_time     <= owm_pkg::SHORT_LOW_DEF;
      read_low_time      <= owm_pkg::READ_LOW_DEF;
      slot_time          <= owm_pkg::SLOT_DEF;
      recovery_time      <= owm_pkg::RECOVERY_DEF;
    end else if (cfg_we) begin
      case (owm_pkg::reg_idx_t'(cfg_index))
        owm_pkg::REG_RESET_LOW:     reset_low_time     <= cfg_data;
        owm_pkg::REG_PRESENCE_WAIT: presence_wait_time <= cfg_data;
        owm_pkg::REG_RESET_TAIL:    reset_tail_time    <= cfg_data;
        owm_pkg::REG_SHORT_LOW:     short_low_time     <= cfg_data[3:0];
        owm_pkg::REG_READ_LOW:      read_low_time      <= cfg_data[3:0];
        owm_pkg::REG_SLOT:          slot_time          <= cfg_data[6:0];
        owm_pkg::REG_RECOVERY:      recovery_time      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    logic [CW-1:0] len, srel_len, tc1;
    logic [CW:0]   tc_inc;
    logic          cur_bit, finish, end_slot;

    ph0  = phase;
    tc0  = tick_count;
    bi0  = bit_index;
    sb0  = shift_byte;
    opr0 = op_is_read;
    if (phase == owm_pkg::PH_IDLE && owm_pkg::func_t'(func) != owm_pkg::FUNC_TICK) begin
      tc0 = '0;
      bi0 = '0;
      if (owm_pkg::func_t'(func) == owm_pkg::FUNC_RESET) begin
        opr0 = 1'b0;
        ph0  = owm_pkg::PH_RLOW;
      end else begin
        opr0 = (owm_pkg::func_t'(func) == owm_pkg::FUNC_READ);
        sb0  = opr0 ? 8'd0 : write_byte;
        ph0  = owm_pkg::PH_SLOW;
      end
    end

    cur_bit = sb0[bi0];
    srel_len = (!opr0 && !cur_bit) ? CW'(recovery_time)
                                   : owm_pkg::at_least_one(CW'(slot_time));
    case (ph0)
      owm_pkg::PH_RLOW:  len = owm_pkg::at_least_one(reset_low_time);
      owm_pkg::PH_RWAIT: len = owm_pkg::at_least_one(presence_wait_time);
      owm_pkg::PH_RTAIL: len = reset_tail_time;
      owm_pkg::PH_SLOW: begin
        if (opr0)         len = owm_pkg::at_least_one(CW'(read_low_time));
        else if (cur_bit) len = owm_pkg::at_least_one(CW'(short_low_time));
        else              len = owm_pkg::at_least_one(CW'(slot_time));
      end
      owm_pkg::PH_SREL:  len = srel_len;
      default:           len = CW'(1);
    endcase

    tc_inc = {1'b0, tc0} + (CW+1)'(1);
    tc1    = tc_inc[CW-1:0];

    phase_next         = ph0;
    tick_count_next    = tc0;
    bit_index_next     = bi0;
    shift_byte_next    = sb0;
    op_is_read_next    = opr0;
    presence_flag_next = presence_flag;
    held_read_next     = held_read;
    finish             = 1'b0;
    end_slot           = 1'b0;

    if (ph0 != owm_pkg::PH_IDLE) begin
      if (ph0 == owm_pkg::PH_RWAIT && tc_inc >= {1'b0, len})
        presence_flag_next = ~bus_level;
      if (ph0 == owm_pkg::PH_SREL && opr0 && tc0 == '0 && bus_level)
        shift_byte_next[bi0] = 1'b1;
      tick_count_next = tc1;
      // part has run out (a wrapped count also ends it)
      if (tc1 >= len || tc1 == '0) begin
        tick_count_next = '0;
        case (ph0)
          owm_pkg::PH_RLOW:  phase_next = owm_pkg::PH_RWAIT;
          owm_pkg::PH_RWAIT: begin
            phase_next = owm_pkg::PH_RTAIL;
            finish     = (reset_tail_time == '0);
          end
          owm_pkg::PH_RTAIL: finish = 1'b1;
          owm_pkg::PH_SLOW: begin
            phase_next = owm_pkg::PH_SREL;
            end_slot   = (srel_len == '0);
          end
          owm_pkg::PH_SREL:  end_slot = 1'b1;
          default:           finish = 1'b1;
        endcase
        if (end_slot) begin
          if (bi0 == 3'd7) begin
            finish = 1'b1;
          end else begin
            bit_index_next = bi0 + 3'd1;
            phase_next     = owm_pkg::PH_SLOW;
          end
        end
        if (finish) begin
          phase_next = owm_pkg::PH_IDLE;
          if (opr0) held_read_next = shift_byte_next;
        end
      end
    end
  end

  // tick outputs
  always_comb begin
    tick_busy  = (ph0 != owm_pkg::PH_IDLE);
    tick_drive = (ph0 == owm_pkg::PH_RLOW) || (ph0 == owm_pkg::PH_SLOW);
    tick_done  = tick_busy && (phase_next == owm_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= owm_pkg::PH_IDLE;
      tick_count    <= '0;
      bit_index     <= '0;
      shift_byte    <= '0;
      presence_flag <= 1'b0;
      op_is_read    <= 1'b0;
      held_read     <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      bit_index     <= bit_index_next;
      shift_byte    <= shift_byte_next;
      presence_flag <= presence_flag_next;
      op_is_read    <= op_is_read_next;
      held_read     <= held_read_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      drive_low <= tick_drive;
      busy_res  <= tick_busy;
      done_res  <= tick_done;
      presence  <= presence_flag_next;
      read_byte <= held_read_next;
    end
  end

endmodule
